### rtl/core/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg: shared types and constants of the UTF-8 source validator
// Verdict codes, byte classes, counter limits, state and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8v_pkg;

	localparam int CNT_W = 21;
	localparam int OFS_W = 20;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [OFS_W-1:0] OFS_MAX = {OFS_W{1'b1}};

	// Host-side source length limit; the position counter stops there.
	localparam longint unsigned MAX_SOURCE_BYTES = 1048576;
	localparam logic [CNT_W-1:0] POS_LIMIT =
		(MAX_SOURCE_BYTES > longint'(CNT_MAX)) ? CNT_MAX : CNT_W'(MAX_SOURCE_BYTES);

	// Byte classes
	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] BYTE_LF    = 8'h0a;
	localparam logic [7:0] ASCII_END  = 8'h80;
	localparam logic [7:0] LEAD2_MIN  = 8'hc2;
	localparam logic [7:0] LEAD2_MAX  = 8'hdf;
	localparam logic [7:0] LEAD3_MIN  = 8'he0;
	localparam logic [7:0] LEAD3_MAX  = 8'hef;
	localparam logic [7:0] LEAD4_MIN  = 8'hf0;
	localparam logic [7:0] LEAD4_MAX  = 8'hf4;
	localparam logic [1:0] CONT_TAG   = 2'b10;
	localparam logic [7:0] BOM_BYTE0  = 8'hef;
	localparam logic [7:0] BOM_BYTE1  = 8'hbb;
	localparam logic [7:0] BOM_BYTE2  = 8'hbf;

	// Code point limits
	localparam logic [CNT_W-1:0] CP_MIN3    = 21'h000800;
	localparam logic [CNT_W-1:0] CP_MIN4    = 21'h010000;
	localparam logic [CNT_W-1:0] CP_MAX     = 21'h10ffff;
	localparam logic [CNT_W-1:0] SURR_FIRST = 21'h00d800;
	localparam logic [CNT_W-1:0] SURR_LAST  = 21'h00dfff;

	typedef enum logic [2:0] {
		VERDICT_RUN  = 3'd0,
		VERDICT_DONE = 3'd1,
		VERDICT_BAD  = 3'd2,
		VERDICT_NUL  = 3'd3,
		VERDICT_MARK = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [1:0]       pending;
		logic [2:0]       seq_len;
		logic [CNT_W-1:0] code_point;
		logic [CNT_W-1:0] byte_pos;
		logic [CNT_W-1:0] cur_line;
		logic [CNT_W-1:0] cur_col;
		logic [CNT_W-1:0] start_pos;
		logic [CNT_W-1:0] start_line;
		logic [CNT_W-1:0] start_col;
		logic [1:0]       mark_cnt;
		verdict_t         verdict;
	} state_t;

	localparam state_t STATE_RESET = '{
		pending:    2'd0,
		seq_len:    3'd0,
		code_point: '0,
		byte_pos:   '0,
		cur_line:   CNT_W'(1),
		cur_col:    CNT_W'(1),
		start_pos:  '0,
		start_line: CNT_W'(1),
		start_col:  CNT_W'(1),
		mark_cnt:   2'd0,
		verdict:    VERDICT_RUN
	};

	typedef struct packed {
		verdict_t         verdict;
		logic [OFS_W-1:0] error_offset;
		logic [CNT_W-1:0] error_line;
		logic [CNT_W-1:0] error_column;
		logic             end_of_source;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/utf8v_byte_if.sv
// ----------------------------------------------------------------------------
// utf8v_byte_if: source byte channel
// Valid/ready channel carrying one source byte and its end marker per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8v_result_if.sv
// ----------------------------------------------------------------------------
// utf8v_result_if: validation result channel
// Valid/ready channel carrying one verdict word per source byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8v_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [19:0] error_offset;
	logic [20:0] error_line;
	logic [20:0] error_column;
	logic        end_of_source;

	modport source (output valid, output verdict, output error_offset, output error_line,
		output error_column, output end_of_source, input ready);
	modport sink   (input valid, input verdict, input error_offset, input error_line,
		input error_column, input end_of_source, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8v_step.sv
// ----------------------------------------------------------------------------
// utf8v_step: one-byte decode step
// Next decoder state and the result word for one source byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_step (
	input  utf8v_pkg::state_t  state,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output utf8v_pkg::state_t  next_state,
	output utf8v_pkg::result_t result
);

	utf8v_pkg::state_t   n;
	utf8v_pkg::verdict_t err;
	logic [utf8v_pkg::CNT_W-1:0] cp_new;
	logic [utf8v_pkg::CNT_W:0]   col_sum;
	logic [1:0]                  pend_dec;

	always_comb begin
		n        = state;
		err      = utf8v_pkg::VERDICT_RUN;
		cp_new   = {state.code_point[utf8v_pkg::CNT_W-7:0], data_byte[5:0]};
		pend_dec = state.pending - 2'd1;
		col_sum  = {1'b0, state.cur_col} + (utf8v_pkg::CNT_W+1)'(state.seq_len);

		if (state.verdict == utf8v_pkg::VERDICT_RUN) begin
			// byte-order mark tracker
			if (state.byte_pos == '0 && data_byte == utf8v_pkg::BOM_BYTE0) begin
				n.mark_cnt = 2'd1;
			end else if (state.byte_pos == utf8v_pkg::CNT_W'(1) && state.mark_cnt == 2'd1
					&& data_byte == utf8v_pkg::BOM_BYTE1) begin
				n.mark_cnt = 2'd2;
			end else if (state.byte_pos == utf8v_pkg::CNT_W'(2) && state.mark_cnt == 2'd2
					&& data_byte == utf8v_pkg::BOM_BYTE2) begin
				n.mark_cnt = 2'd3;
			end else begin
				n.mark_cnt = 2'd0;
			end

			if (state.pending == 2'd0) begin
				n.start_pos  = state.byte_pos;
				n.start_line = state.cur_line;
				n.start_col  = state.cur_col;
				if (data_byte == utf8v_pkg::BYTE_NUL) begin
					err = utf8v_pkg::VERDICT_NUL;
				end else if (data_byte < utf8v_pkg::ASCII_END) begin
					// single-byte sequence completes at once
					if (data_byte == utf8v_pkg::BYTE_LF) begin
						if (state.cur_line != utf8v_pkg::CNT_MAX) begin
							n.cur_line = state.cur_line + utf8v_pkg::CNT_W'(1);
						end
						n.cur_col = utf8v_pkg::CNT_W'(1);
					end else if (state.cur_col != utf8v_pkg::CNT_MAX) begin
						n.cur_col = state.cur_col + utf8v_pkg::CNT_W'(1);
					end
					n.seq_len    = 3'd0;
					n.code_point = '0;
				end else if (data_byte >= utf8v_pkg::LEAD2_MIN
						&& data_byte <= utf8v_pkg::LEAD2_MAX) begin
					n.seq_len    = 3'd2;
					n.code_point = utf8v_pkg::CNT_W'(data_byte[4:0]);
					n.pending    = 2'd1;
				end else if (data_byte >= utf8v_pkg::LEAD3_MIN
						&& data_byte <= utf8v_pkg::LEAD3_MAX) begin
					n.seq_len    = 3'd3;
					n.code_point = utf8v_pkg::CNT_W'(data_byte[3:0]);
					n.pending    = 2'd2;
				end else if (data_byte >= utf8v_pkg::LEAD4_MIN
						&& data_byte <= utf8v_pkg::LEAD4_MAX) begin
					n.seq_len    = 3'd4;
					n.code_point = utf8v_pkg::CNT_W'(data_byte[2:0]);
					n.pending    = 2'd3;
				end else begin
					err = utf8v_pkg::VERDICT_BAD;
				end
			end else begin
				if (data_byte[7:6] != utf8v_pkg::CONT_TAG) begin
					err = utf8v_pkg::VERDICT_BAD;
				end else begin
					n.code_point = cp_new;
					n.pending    = pend_dec;
					if (pend_dec == 2'd0) begin
						if ((state.seq_len == 3'd3 && cp_new < utf8v_pkg::CP_MIN3)
								|| (state.seq_len == 3'd4 && cp_new < utf8v_pkg::CP_MIN4)
								|| cp_new > utf8v_pkg::CP_MAX
								|| (cp_new >= utf8v_pkg::SURR_FIRST
									&& cp_new <= utf8v_pkg::SURR_LAST)) begin
							err = utf8v_pkg::VERDICT_BAD;
						end else if (n.mark_cnt == 2'd3) begin
							err = utf8v_pkg::VERDICT_MARK;
						end else begin
							// multi-byte sequence: column moves by its length
							n.cur_col = (col_sum > {1'b0, utf8v_pkg::CNT_MAX})
								? utf8v_pkg::CNT_MAX : col_sum[utf8v_pkg::CNT_W-1:0];
							n.seq_len    = 3'd0;
							n.code_point = '0;
						end
					end
				end
			end

			if (state.byte_pos < utf8v_pkg::POS_LIMIT) begin
				n.byte_pos = state.byte_pos + utf8v_pkg::CNT_W'(1);
			end

			// sequence cut short by the end of the source
			if (err == utf8v_pkg::VERDICT_RUN && n.pending != 2'd0 && last_byte) begin
				err = utf8v_pkg::VERDICT_BAD;
			end
			if (err != utf8v_pkg::VERDICT_RUN) begin
				n.verdict = err;
			end
		end
	end

	always_comb begin
		result.end_of_source = last_byte;
		if (n.verdict != utf8v_pkg::VERDICT_RUN) begin
			result.verdict      = n.verdict;
			result.error_offset = (n.start_pos > utf8v_pkg::CNT_W'(utf8v_pkg::OFS_MAX))
				? utf8v_pkg::OFS_MAX : n.start_pos[utf8v_pkg::OFS_W-1:0];
			result.error_line   = n.start_line;
			result.error_column = n.start_col;
		end else begin
			result.verdict      = last_byte ? utf8v_pkg::VERDICT_DONE : utf8v_pkg::VERDICT_RUN;
			result.error_offset = '0;
			result.error_line   = '0;
			result.error_column = '0;
		end
	end

	assign next_state = last_byte ? utf8v_pkg::STATE_RESET : n;

endmodule

`default_nettype wire

### rtl/core/utf8v_out_buf.sv
// ----------------------------------------------------------------------------
// utf8v_out_buf: two-entry result buffer
// Holds finished result words; the input side waits only while both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8v_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  utf8v_pkg::result_t push_data,
	utf8v_result_if.source     res
);

	utf8v_pkg::result_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != 2'd2);
	assign push       = push_valid && push_ready;
	assign pop        = res.valid && res.ready;

	assign res.valid         = (count_q != 2'd0);
	assign res.verdict       = entry_q[rd_ptr_q].verdict;
	assign res.error_offset  = entry_q[rd_ptr_q].error_offset;
	assign res.error_line    = entry_q[rd_ptr_q].error_line;
	assign res.error_column  = entry_q[rd_ptr_q].error_column;
	assign res.end_of_source = entry_q[rd_ptr_q].end_of_source;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/core/utf8_source_validator.sv
// ----------------------------------------------------------------------------
// utf8_source_validator: strict UTF-8 check of a source text
// Byte-serial validator with offset, line and byte-column tracking and a
// latched first error (invalid UTF-8, NUL at a sequence start, leading BOM).
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                          | handshake
//  --------+-----+-------------------------------------------------+----------
//  src     | in  | data_byte[7:0], last_byte                       | valid/ready
//  res     | out | verdict[2:0], error_offset[19:0], error_line,   | valid/ready
//          |     | error_column[20:0], end_of_source               |
//
//  One word in, one word out. A source byte is decoded in the cycle it is
//  accepted; its result word is registered and waits behind older words.
//  Sustained rate: one word per cycle while res takes words, set by the single
//  decode step between the state registers and the two-entry result buffer.
//  src.ready drops only while both buffer entries hold untaken words.
//  Reset (arst_n low) returns all counters and the latched verdict to start;
//  the final byte of a source does the same at its acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_source_validator (
	input  logic           clk,
	input  logic           arst_n,
	utf8v_byte_if.sink     src,
	utf8v_result_if.source res
);

	// decoder state: counters, partial code point, BOM tracker, latched verdict
	utf8v_pkg::state_t  state_q;
	utf8v_pkg::state_t  state_next;
	utf8v_pkg::result_t step_result;
	logic               buf_ready;
	logic               accept;

	assign src.ready = buf_ready;
	assign accept    = src.valid && buf_ready;

	// combinational decode of the current byte against the stored state
	utf8v_step u_step (
		.state      (state_q),
		.data_byte  (src.data_byte),
		.last_byte  (src.last_byte),
		.next_state (state_next),
		.result     (step_result)
	);

	// state advances only on an accepted word; the step logic already folds
	// in the end-of-source return to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= utf8v_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	// result words queue here; decouples the output stall from src.ready
	utf8v_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (src.valid),
		.push_ready (buf_ready),
		.push_data  (step_result),
		.res        (res)
	);

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UTF-8 source validator
// Streams short source texts (a hand-written set of corner cases, then random
// texts built mostly from well-formed characters with injected faults) through
// the byte channel with random idling on both sides. A cycle-free decoder
// model predicts the words that carry no hand-written result, and a scoreboard checks all in order.
// ----------------------------------------------------------------------------

module tb_top;
	import utf8v_pkg::*;

	// ------------------------------------------------------------------------
	// Run sizing
	// ------------------------------------------------------------------------
	localparam int PLAN_ROWS     = 26;   // hand-written words
	localparam int RANDOM_WORDS  = 400;  // random words after them (approx.)
	localparam int HOLD_CYCLES   = 96;   // one long back-pressure stretch
	localparam int HOLD_AFTER    = 150;  // ...started once this many results are taken
	localparam int SETTLE_CYCLES = 8;    // spare cycles at the end
	localparam int STALL_LIMIT   = 1000; // cycles with no word moving on either side

	// One source word as the sender sees it. Rows with 'typed' set carry their
	// result written out by hand; all others are checked against the decoder.
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       typed;
		result_t    want;
	} byte_word_t;

	localparam result_t RUN_WORD  = '{VERDICT_RUN, 20'd0, 21'd0, 21'd0, 1'b0};
	localparam result_t DONE_WORD = '{VERDICT_DONE, 20'd0, 21'd0, 21'd0, 1'b1};

	// Directed texts. The error position always names the start of the
	// offending sequence, not the byte where it was noticed.
	localparam byte_word_t PLAN [PLAN_ROWS] = '{
		// plain ASCII with a newline, finishes clean
		'{8'h41, 1'b0, 1'b1, RUN_WORD},
		'{8'h0a, 1'b0, 1'b1, RUN_WORD},
		'{8'h7f, 1'b1, 1'b1, DONE_WORD},
		// NUL as the very first byte
		'{8'h00, 1'b1, 1'b1, '{VERDICT_NUL, 20'd0, 21'd1, 21'd1, 1'b1}},
		// leading byte-order mark, flagged on its third byte, then held
		'{8'hef, 1'b0, 1'b1, RUN_WORD},
		'{8'hbb, 1'b0, 1'b1, RUN_WORD},
		'{8'hbf, 1'b0, 1'b1, '{VERDICT_MARK, 20'd0, 21'd1, 21'd1, 1'b0}},
		'{8'h41, 1'b1, 1'b1, '{VERDICT_MARK, 20'd0, 21'd1, 21'd1, 1'b1}},
		// highest code point U+10FFFF
		'{8'hf4, 1'b0, 1'b0, '0},
		'{8'h8f, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b1, 1'b1, DONE_WORD},
		// overlong three-byte form on line 2
		'{8'h0a, 1'b0, 1'b1, RUN_WORD},
		'{8'he0, 1'b0, 1'b0, '0},
		'{8'h9f, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b1, 1'b1, '{VERDICT_BAD, 20'd1, 21'd2, 21'd1, 1'b1}},
		// C0 can never lead
		'{8'hc0, 1'b1, 1'b1, '{VERDICT_BAD, 20'd0, 21'd1, 21'd1, 1'b1}},
		// surrogate U+D800
		'{8'hed, 1'b0, 1'b0, '0},
		'{8'ha0, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b1, '{VERDICT_BAD, 20'd0, 21'd1, 21'd1, 1'b1}},
		// U+110000, just past the top
		'{8'hf4, 1'b0, 1'b0, '0},
		'{8'h90, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		'{8'h80, 1'b1, 1'b1, '{VERDICT_BAD, 20'd0, 21'd1, 21'd1, 1'b1}},
		// two-byte lead cut off by the end of the text
		'{8'h41, 1'b0, 1'b1, RUN_WORD},
		'{8'hc3, 1'b1, 1'b1, '{VERDICT_BAD, 20'd1, 21'd1, 21'd2, 1'b1}}
	};

	// ------------------------------------------------------------------------
	// Clock, reset, DUT
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	utf8v_byte_if   src ();
	utf8v_result_if res ();

	utf8_source_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.res    (res)
	);

	// ------------------------------------------------------------------------
	// Decoder model: one call per accepted source byte, returns its result word
	// ------------------------------------------------------------------------
	typedef struct packed {
		logic [1:0]       need;     // continuation bytes still owed
		logic [2:0]       len;      // length of the open sequence
		logic [CNT_W-1:0] cp;       // code point gathered so far
		logic [CNT_W-1:0] pos;      // byte offset of the next byte
		logic [CNT_W-1:0] line;
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] s_pos;    // where the open sequence started
		logic [CNT_W-1:0] s_line;
		logic [CNT_W-1:0] s_col;
		logic [1:0]       bom;      // how much of EF BB BF has been seen
		verdict_t         latched;  // first error, held until end of text
	} decoder_t;

	decoder_t dec;

	function automatic void clear_decoder();
		dec         = '0;
		dec.line    = CNT_W'(1);
		dec.col     = CNT_W'(1);
		dec.s_line  = CNT_W'(1);
		dec.s_col   = CNT_W'(1);
		dec.latched = VERDICT_RUN;
	endfunction

	// A finished LF starts a new line; anything else moves the byte column.
	function automatic void close_sequence(input logic [7:0] lead);
		int unsigned sum;
		if (dec.len == 3'd1 && lead == BYTE_LF) begin
			if (dec.line < CNT_MAX)
				dec.line = dec.line + 1'b1;
			dec.col = CNT_W'(1);
		end else begin
			sum = dec.col + dec.len;
			dec.col = (sum > CNT_MAX) ? CNT_MAX : sum[CNT_W-1:0];
		end
		dec.len = '0;
		dec.cp  = '0;
	endfunction

	function automatic result_t decode_byte(input logic [7:0] b, input logic fin);
		verdict_t err;
		result_t  r;
		err = VERDICT_RUN;
		if (dec.latched == VERDICT_RUN) begin
			// byte-order mark only counts at offsets 0..2
			if (dec.pos == 0 && b == BOM_BYTE0)
				dec.bom = 2'd1;
			else if (dec.pos == 1 && dec.bom == 2'd1 && b == BOM_BYTE1)
				dec.bom = 2'd2;
			else if (dec.pos == 2 && dec.bom == 2'd2 && b == BOM_BYTE2)
				dec.bom = 2'd3;
			else
				dec.bom = 2'd0;

			if (dec.need == 2'd0) begin
				dec.s_pos  = dec.pos;
				dec.s_line = dec.line;
				dec.s_col  = dec.col;
				if (b == BYTE_NUL) begin
					err = VERDICT_NUL;
				end else if (b < ASCII_END) begin
					dec.len = 3'd1;
					close_sequence(b);
				end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					dec.len = 3'd2;
					dec.cp  = CNT_W'(b[4:0]);
				end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
					dec.len = 3'd3;
					dec.cp  = CNT_W'(b[3:0]);
				end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
					dec.len = 3'd4;
					dec.cp  = CNT_W'(b[2:0]);
				end else begin
					err = VERDICT_BAD;
				end
				if (err == VERDICT_RUN && dec.len > 3'd1)
					dec.need = 2'(dec.len - 3'd1);
			end else if (b[7:6] != CONT_TAG) begin
				err = VERDICT_BAD;
			end else begin
				dec.cp   = {dec.cp[CNT_W-7:0], b[5:0]};
				dec.need = dec.need - 2'd1;
				if (dec.need == 2'd0) begin
					if ((dec.len == 3'd3 && dec.cp < CP_MIN3) ||
					    (dec.len == 3'd4 && dec.cp < CP_MIN4) ||
					    dec.cp > CP_MAX ||
					    (dec.cp >= SURR_FIRST && dec.cp <= SURR_LAST))
						err = VERDICT_BAD;
					else if (dec.bom == 2'd3)
						err = VERDICT_MARK;
					else
						close_sequence(b);
				end
			end

			if (dec.pos < POS_LIMIT)
				dec.pos = dec.pos + 1'b1;
			// text ends inside a sequence
			if (err == VERDICT_RUN && dec.need != 2'd0 && fin)
				err = VERDICT_BAD;
			if (err != VERDICT_RUN)
				dec.latched = err;
		end

		if (dec.latched != VERDICT_RUN) begin
			r.verdict      = dec.latched;
			r.error_offset = (dec.s_pos > CNT_W'(OFS_MAX)) ? OFS_MAX : dec.s_pos[OFS_W-1:0];
			r.error_line   = dec.s_line;
			r.error_column = dec.s_col;
		end else begin
			r.verdict      = fin ? VERDICT_DONE : VERDICT_RUN;
			r.error_offset = '0;
			r.error_line   = '0;
			r.error_column = '0;
		end
		r.end_of_source = fin;
		if (fin)
			clear_decoder();
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Random texts: mostly legal characters, about one in six a fault
	// ------------------------------------------------------------------------
	byte_word_t source_words[$];  // everything the sender will offer, in order
	logic [7:0] text_bytes[$];    // text being assembled

	function automatic int unsigned legal_code_point(input int len);
		int unsigned cp;
		case (len)
			2: cp = $urandom_range(32'h80, 32'h7ff);
			3: begin
				// skip the surrogate block by folding it onto the top
				cp = $urandom_range(32'h800, 32'hf7ff);
				if (cp >= 32'hd800)
					cp = cp + 32'h800;
			end
			default: cp = $urandom_range(32'h10000, 32'h10ffff);
		endcase
		return cp;
	endfunction

	// Plain UTF-8 encoding at a forced length, so overlong forms come out too.
	task automatic put_char(input int unsigned cp, input int len);
		case (len)
			1: text_bytes.push_back(cp[7:0]);
			2: begin
				text_bytes.push_back({3'b110, cp[10:6]});
				text_bytes.push_back({2'b10, cp[5:0]});
			end
			3: begin
				text_bytes.push_back({4'b1110, cp[15:12]});
				text_bytes.push_back({2'b10, cp[11:6]});
				text_bytes.push_back({2'b10, cp[5:0]});
			end
			default: begin
				text_bytes.push_back({5'b11110, cp[20:18]});
				text_bytes.push_back({2'b10, cp[17:12]});
				text_bytes.push_back({2'b10, cp[11:6]});
				text_bytes.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic add_random_text();
		int          n_chars;
		int          pick;
		int          len;
		int          cut;
		int unsigned b;
		bit          ended;
		byte_word_t  w;
		text_bytes.delete();
		ended = 1'b0;

		// a real mark now and then, or EF BB followed by something else
		if ($urandom_range(0, 9) == 0)
			put_char(32'hfeff, 3);
		else if ($urandom_range(0, 14) == 0)
			put_char($urandom_range(32'hfec0, 32'hfefe), 3);

		n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		for (int k = 0; k < n_chars && !ended; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				put_char(($urandom_range(0, 7) == 0) ? 32'(BYTE_LF) : $urandom_range(1, 127), 1);
			end else if (pick < 55) begin
				put_char(legal_code_point(2), 2);
			end else if (pick < 70) begin
				put_char(legal_code_point(3), 3);
			end else if (pick < 82) begin
				put_char(legal_code_point(4), 4);
			end else begin
				len = $urandom_range(2, 4);
				case ($urandom_range(0, 8))
					0: text_bytes.push_back(8'($urandom_range(0, 255)));
					1: text_bytes.push_back(BYTE_NUL);
					2: put_char($urandom_range(0, 32'h7ff), 3);          // overlong
					3: put_char($urandom_range(0, 32'hffff), 4);         // overlong
					4: put_char($urandom_range(32'hd800, 32'hdfff), 3);  // surrogate
					5: put_char($urandom_range(32'h110000, 32'h1fffff), 4);
					6: begin
						// one continuation replaced by a byte outside 80-BF
						put_char(legal_code_point(len), len);
						b = $urandom_range(0, 191);
						if (b >= 128)
							b = b + 64;
						cut = $urandom_range(1, len - 1);
						text_bytes[text_bytes.size() - cut] = b[7:0];
					end
					7: begin
						// text stops inside a sequence
						put_char(legal_code_point(len), len);
						cut = $urandom_range(1, len - 1);
						repeat (cut) void'(text_bytes.pop_back());
						ended = 1'b1;
					end
					default: text_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
				endcase
			end
		end

		foreach (text_bytes[k]) begin
			w       = '0;
			w.data  = text_bytes[k];
			w.fin   = (k == text_bytes.size() - 1);
			source_words.push_back(w);
		end
	endtask

	// Idle cycles before the next word: none, any 0..19, or mostly none.
	function automatic int draw_idle(input int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(0, 19);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Scoreboard state
	// ------------------------------------------------------------------------
	result_t pending_verdicts[$];  // predicted result words, oldest first
	int      outstanding  = 0;
	int      taken_words  = 0;     // source words accepted so far
	int      failures     = 0;
	int      stall_cycles = 0;
	int      tally [5]    = '{default: 0};  // texts by closing verdict
	bit      plan_ready   = 1'b0;
	bit      feed_done    = 1'b0;

	// ------------------------------------------------------------------------
	// Sender: walks source_words, idles per word
	// ------------------------------------------------------------------------
	initial begin : feed
		int gap_mode;
		int gap;
		src.valid     <= 1'b0;
		src.data_byte <= '0;
		src.last_byte <= 1'b0;
		gap_mode = 0;
		wait (plan_ready && arst_n);
		@(posedge clk);
		for (int i = 0; i < source_words.size(); i++) begin
			if (i % 40 == 0)
				gap_mode = $urandom_range(0, 2);
			gap = draw_idle(gap_mode);
			if (gap > 0) begin
				src.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// valid stays up across back-to-back words
			src.valid     <= 1'b1;
			src.data_byte <= source_words[i].data;
			src.last_byte <= source_words[i].fin;
			@(posedge clk);
			while (!src.ready)
				@(posedge clk);
		end
		src.valid <= 1'b0;
		feed_done = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold so the result buffer fills
	// and src.ready has to drop while the sender keeps offering.
	// ------------------------------------------------------------------------
	initial begin : drain
		int gap_mode;
		int gap;
		int got;
		bit held;
		res.ready <= 1'b0;
		gap_mode = 0;
		got      = 0;
		held     = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (got % 40 == 0)
				gap_mode = $urandom_range(0, 2);
			gap = draw_idle(gap_mode);
			if (!held && got >= HOLD_AFTER) begin
				gap  = HOLD_CYCLES;
				held = 1'b1;
			end
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid)
				@(posedge clk);
			got++;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: everything sampled at the rising edge, so pre-edge values.
	// Results are checked before new predictions are queued; every result word is registered
	// in the result buffer, so a word accepted at this edge cannot have its result here as well.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t want;
		result_t model;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;

			if (res.valid && res.ready) begin
				moved = 1'b1;
				if (pending_verdicts.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result word with nothing pending: verdict %0d ofs %0d",
							$realtime, res.verdict, res.error_offset);
				end else begin
					want = pending_verdicts.pop_front();
					outstanding--;
					if (res.verdict !== want.verdict ||
					    res.error_offset !== want.error_offset ||
					    res.error_line !== want.error_line ||
					    res.error_column !== want.error_column ||
					    res.end_of_source !== want.end_of_source) begin
						failures++;
						if (failures <= 10) begin
							$display("%0t: mismatch exp verdict %0d ofs %0d line %0d col %0d eos %0d",
								$realtime, want.verdict, want.error_offset, want.error_line,
								want.error_column, want.end_of_source);
							$display("    got verdict %0d ofs %0d line %0d col %0d eos %0d",
								res.verdict, res.error_offset, res.error_line,
								res.error_column, res.end_of_source);
						end
					end
				end
			end

			if (src.valid && src.ready) begin
				moved = 1'b1;
				// the model always runs so its state tracks the stream
				model = decode_byte(src.data_byte, src.last_byte);
				want  = source_words[taken_words].typed ? source_words[taken_words].want : model;
				pending_verdicts.push_back(want);
				outstanding++;
				taken_words++;
				if (want.end_of_source)
					tally[want.verdict]++;
			end

			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t: no word moved for %0d cycles, %0d results outstanding",
			$realtime, STALL_LIMIT, outstanding);
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : run
		arst_n = 1'b0;
		clear_decoder();
		for (int k = 0; k < PLAN_ROWS; k++)
			source_words.push_back(PLAN[k]);
		while (source_words.size() < PLAN_ROWS + RANDOM_WORDS)
			add_random_text();
		plan_ready = 1'b1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (feed_done);
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d words in %0d texts: %0d clean, %0d invalid, %0d NUL, %0d with mark",
			taken_words, tally[VERDICT_DONE] + tally[VERDICT_BAD] + tally[VERDICT_NUL]
			+ tally[VERDICT_MARK], tally[VERDICT_DONE], tally[VERDICT_BAD],
			tally[VERDICT_NUL], tally[VERDICT_MARK]);
		$display("random idling on both channels, one %0d-cycle result hold; %0d failures",
			HOLD_CYCLES, failures);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
